@@ hw/rtl/pfa_pkg.sv @@
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int FRAME_BITS    = 16;
    localparam int FRESH_BITS    = FRAME_BITS + 1;
    localparam int COUNT_BITS    = 17;
    localparam int REGION_BITS   = 8;
    localparam int REGION_FRAMES = 512;
    localparam int REGION_SHIFT  = $clog2(REGION_FRAMES);
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 17;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AREA1_FIRST  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AREA1_COUNT  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AREA2_FIRST  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AREA2_REGIONS = 3'd4;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK  = 2'd0,
        STATUS_OOM = 2'd1,
        STATUS_OFF = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_POP  = 1'b1
    } state_t;

    // one link of the freed list: next older frame and whether it exists
    typedef struct packed {
        logic                  more;
        logic [FRAME_BITS-1:0] next;
    } link_t;

    typedef struct packed {
        logic                  wr_en;
        logic [FRAME_BITS-1:0] wr_addr;
        link_t                 wr_data;
        logic                  rd_en;
        logic [FRAME_BITS-1:0] rd_addr;
    } link_req_t;

endpackage

@@ hw/rtl/page_frame_free_list_allocator_unit.sv @@
`timescale 1ns / 1ps
// Results: a free or a fresh-frame allocate is written straight into the output register;
// an allocate served from the freed list is first read from the link memory, then registered.
// Throughput: one request per cycle for frees and fresh allocates unless the output stalls;
// a pop takes no new request until its result has moved into the output register.
// Reset: all control state cleared, allocator disabled; link memory is not cleared.
module page_frame_free_list_allocator_unit
    import pfa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [15:0]              s_tdata,   // [15:0] freed_frame
    input  logic [0:0]               s_tuser,   // [0] operation
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [15:0]              m_tdata,   // [15:0] frame
    output logic [1:0]               m_tuser    // [1:0] status
);

    state_t state_reg, state_next;

    logic                   enable_reg;
    logic [FRAME_BITS-1:0]  area1_first_reg;
    logic [COUNT_BITS-1:0]  area1_count_reg;
    logic [FRAME_BITS-1:0]  area2_first_reg;
    logic [REGION_BITS-1:0] area2_regions_reg;

    logic [FRAME_BITS-1:0]  head_reg, head_next;
    logic                   nonempty_reg, nonempty_next;
    logic [FRESH_BITS-1:0]  fresh_frame_reg, fresh_frame_next;
    logic [COUNT_BITS-1:0]  fresh_left_reg, fresh_left_next;
    logic [REGION_BITS-1:0] regions_reg, regions_next;

    logic                   out_valid_reg, out_valid_next;
    logic [FRAME_BITS-1:0]  out_frame_reg, out_frame_next;
    status_t                out_status_reg, out_status_next;

    link_req_t ram_req;
    link_t     ram_rd_data;

    logic accept;
    logic out_free;
    logic is_free;
    logic is_pop;
    logic pop_done;
    logic need_region;
    logic [FRESH_BITS-1:0] cand_frame;
    logic [COUNT_BITS-1:0] cand_left;

    pfa_link_ram u_link_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_free  = op_t'(s_tuser[0]) == OP_FREE;
    assign is_pop   = !is_free && enable_reg && nonempty_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_pop)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready = 1'b0;
        pop_done = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = out_free;
            end
            ST_POP:
            begin
                pop_done = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ram_req.wr_en        = accept && is_free;
        ram_req.wr_addr      = s_tdata[FRAME_BITS-1:0];
        ram_req.wr_data.more = nonempty_reg;
        ram_req.wr_data.next = head_reg;
        ram_req.rd_en        = accept && is_pop;
        ram_req.rd_addr      = head_reg;
    end

    // open the next region of area two once the current run is used up
    assign need_region = (fresh_left_reg == '0) && (regions_reg < area2_regions_reg);

    always_comb
    begin
        if (need_region)
        begin
            cand_frame = FRESH_BITS'(area2_first_reg)
                       + (FRESH_BITS'(regions_reg) << REGION_SHIFT);
            cand_left  = COUNT_BITS'(REGION_FRAMES);
        end
        else
        begin
            cand_frame = fresh_frame_reg;
            cand_left  = fresh_left_reg;
        end
    end

    always_comb
    begin
        head_next        = head_reg;
        nonempty_next    = nonempty_reg;
        fresh_frame_next = fresh_frame_reg;
        fresh_left_next  = fresh_left_reg;
        regions_next     = regions_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_frame_next   = out_frame_reg;
        out_status_next  = out_status_reg;

        if (pop_done)
        begin
            out_valid_next  = 1'b1;
            out_frame_next  = head_reg;
            out_status_next = STATUS_OK;
            if (ram_rd_data.more)
            begin
                head_next = ram_rd_data.next;
            end
            else
            begin
                nonempty_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (is_free)
            begin
                head_next       = s_tdata[FRAME_BITS-1:0];
                nonempty_next   = 1'b1;
                out_valid_next  = 1'b1;
                out_frame_next  = s_tdata[FRAME_BITS-1:0];
                out_status_next = STATUS_OK;
            end
            else if (!enable_reg)
            begin
                out_valid_next  = 1'b1;
                out_frame_next  = '0;
                out_status_next = STATUS_OFF;
            end
            else if (!nonempty_reg)
            begin
                out_valid_next = 1'b1;
                if (cand_left == '0)
                begin
                    out_frame_next  = '0;
                    out_status_next = STATUS_OOM;
                end
                else
                begin
                    out_frame_next   = cand_frame[FRAME_BITS-1:0];
                    out_status_next  = STATUS_OK;
                    fresh_frame_next = cand_frame + FRESH_BITS'(1);
                    fresh_left_next  = cand_left - COUNT_BITS'(1);
                    if (need_region)
                    begin
                        regions_next = regions_reg + REGION_BITS'(1);
                    end
                end
            end
        end

        // enable rising empties the list and restarts from area one
        if (cfg_we && cfg_index == CFG_ENABLE && cfg_wdata[0] && !enable_reg)
        begin
            head_next        = '0;
            nonempty_next    = 1'b0;
            fresh_frame_next = FRESH_BITS'(area1_first_reg);
            fresh_left_next  = area1_count_reg;
            regions_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            enable_reg        <= 1'b0;
            area1_first_reg   <= '0;
            area1_count_reg   <= '0;
            area2_first_reg   <= '0;
            area2_regions_reg <= '0;
            head_reg          <= '0;
            nonempty_reg      <= 1'b0;
            fresh_frame_reg   <= '0;
            fresh_left_reg    <= '0;
            regions_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            nonempty_reg    <= nonempty_next;
            fresh_frame_reg <= fresh_frame_next;
            fresh_left_reg  <= fresh_left_next;
            regions_reg     <= regions_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLE:        enable_reg        <= cfg_wdata[0];
                    CFG_AREA1_FIRST:   area1_first_reg   <= cfg_wdata[FRAME_BITS-1:0];
                    CFG_AREA1_COUNT:   area1_count_reg   <= cfg_wdata[COUNT_BITS-1:0];
                    CFG_AREA2_FIRST:   area2_first_reg   <= cfg_wdata[FRAME_BITS-1:0];
                    CFG_AREA2_REGIONS: area2_regions_reg <= cfg_wdata[REGION_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_frame_reg  <= out_frame_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_frame_reg;
    assign m_tuser  = out_status_reg;

endmodule

@@ hw/rtl/pfa_link_ram.sv @@
`timescale 1ns / 1ps

module pfa_link_ram
    import pfa_pkg::*;
(
    input  logic      clk,
    input  link_req_t req,
    output link_t     rd_data
);

    link_t mem [2**FRAME_BITS];
    link_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
